@@ src/pct_pkg.sv @@
// ----------------------------------------------------------------------------
// Proximity contact tracker package
// Shared types, constants and defaults for the contact tracker.
// ----------------------------------------------------------------------------
package pct_pkg;

	localparam int PEER_SLOTS_DEF = 16;

	localparam logic [1:0] ST_NORMAL = 2'd0;
	localparam logic [1:0] ST_NEAR   = 2'd1;
	localparam logic [1:0] ST_CLOSE  = 2'd2;

	localparam logic [1:0] KIND_MEAS  = 2'd0;
	localparam logic [1:0] KIND_STORE = 2'd1;
	localparam logic [1:0] KIND_SUM   = 2'd2;

	localparam logic [1:0] CFG_THRESH = 2'd0;
	localparam logic [1:0] CFG_DWELL  = 2'd1;
	localparam logic [1:0] CFG_QUIET  = 2'd2;

	localparam logic REQ_MEAS = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef struct packed {
		logic req_type;
		logic [31:0] node_id;
		logic [15:0] distance_cm;
		logic [31:0] timestamp_ms;
		logic standby;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] entry_index;
		logic [31:0] peer_id;
		logic [1:0] status;
		logic close_event;
		logic [15:0] average_cm;
		logic store_request;
		logic [1:0] led_level;
		logic [4:0] close_count;
		logic last;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture input item, clear scan state
		logic scan;      // examine slot under scan index
		logic meas_upd;  // apply measurement update
		logic div_start; // start average divider
		logic div_step;  // one divider step
		logic div_done;  // commit divider result
		logic tick_upd;  // apply tick aging to scanned slot
		logic emit_meas;
		logic emit_store;
		logic emit_sum;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic scan_end;
		logic hit;
		logic need_div;
		logic store_tick;
		logic out_full;
	} sts_t;

endpackage

@@ src/pct_stream_if.sv @@
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface pct_stream_if #(parameter int W = 1);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/pct_datapath.sv @@
// ----------------------------------------------------------------------------
// Contact tracker datapath
// Peer table, config registers, serial lookup, divider and output register.
// ----------------------------------------------------------------------------
module pct_datapath #(
	parameter int PEER_SLOTS = pct_pkg::PEER_SLOTS_DEF,
	localparam int IW = $clog2(PEER_SLOTS)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [15:0] cfg_data,
	input  pct_pkg::in_item_t in_item,
	input  pct_pkg::cmd_t cmd,
	output pct_pkg::sts_t sts,
	output pct_pkg::out_item_t out_item,
	output logic out_valid,
	input  logic out_ready
);
	logic [15:0] thr_q, quiet_q;
	logic [6:0] dwell_q;
	logic [PEER_SLOTS-1:0] valid_q;
	logic [31:0] peer_q [PEER_SLOTS];
	logic [1:0] stat_q [PEER_SLOTS];
	logic [31:0] time_q [PEER_SLOTS];
	logic [31:0] sum_q [PEER_SLOTS];
	logic [7:0] cnt_q [PEER_SLOTS];
	logic [IW-1:0] fill_q, idx_q;
	logic [IW:0] scan_q;
	logic hit_q;
	pct_pkg::in_item_t it_q;
	logic [31:0] quo_q, rem_q;
	logic [1:0] led_q;
	logic [4:0] cc_q;
	logic oval_q;
	logic lapse_q;
	pct_pkg::out_item_t out_q;

	logic [IW-1:0] si;
	logic near, qp_s, qp_i;
	logic [31:0] d_s, d_i;
	logic [32:0] rsh;
	logic [7:0] divisor;
	logic [1:0] st_i, new_tick_st;
	logic emit_any;
	pct_pkg::out_item_t out_nxt;

	assign si = scan_q[IW-1:0];
	assign near = it_q.distance_cm < thr_q;
	assign d_s = it_q.timestamp_ms - time_q[si];
	assign qp_s = !d_s[31] && (d_s >= {16'd0, quiet_q});
	assign d_i = it_q.timestamp_ms - time_q[idx_q];
	assign qp_i = !d_i[31] && (d_i >= {16'd0, quiet_q});
	assign st_i = stat_q[idx_q];
	assign divisor = (cnt_q[idx_q] == 8'd0) ? 8'd1 : cnt_q[idx_q];
	assign rsh = {rem_q, quo_q[31]};
	assign emit_any = cmd.emit_meas || cmd.emit_store || cmd.emit_sum;

	always_comb begin
		new_tick_st = stat_q[si];
		if (stat_q[si] == pct_pkg::ST_CLOSE && !it_q.standby && qp_s)
			new_tick_st = pct_pkg::ST_NORMAL;
		else if (stat_q[si] == pct_pkg::ST_NEAR && qp_s)
			new_tick_st = pct_pkg::ST_NORMAL;
	end

	always_comb begin
		out_nxt = '0;
		if (cmd.emit_meas) begin
			out_nxt.kind = pct_pkg::KIND_MEAS;
			out_nxt.entry_index = 4'(idx_q);
			out_nxt.peer_id = it_q.node_id;
			out_nxt.status = st_i;
			out_nxt.last = 1'b1;
			if (cmd.div_done) begin
				out_nxt.status = pct_pkg::ST_CLOSE;
				out_nxt.close_event = 1'b1;
				out_nxt.average_cm = quo_q[15:0];
			end else if ((st_i == pct_pkg::ST_CLOSE && it_q.standby && near) || lapse_q)
				out_nxt.store_request = 1'b1;
		end else if (cmd.emit_store) begin
			out_nxt.kind = pct_pkg::KIND_STORE;
			out_nxt.entry_index = 4'(si);
			out_nxt.peer_id = peer_q[si];
			out_nxt.status = new_tick_st;
			out_nxt.store_request = 1'b1;
		end else if (cmd.emit_sum) begin
			out_nxt.kind = pct_pkg::KIND_SUM;
			out_nxt.led_level = led_q;
			out_nxt.close_count = cc_q;
			out_nxt.last = 1'b1;
		end
	end

	assign sts.is_tick = it_q.req_type == pct_pkg::REQ_TICK;
	assign sts.scan_end = scan_q == (IW+1)'(PEER_SLOTS);
	assign sts.hit = hit_q;
	assign sts.need_div = st_i == pct_pkg::ST_NEAR && near &&
		{1'b0, cnt_q[idx_q]} >= {2'b0, dwell_q};
	assign sts.store_tick = valid_q[si] && stat_q[si] == pct_pkg::ST_CLOSE &&
		(it_q.standby || qp_s);
	assign sts.out_full = oval_q;
	assign out_item = out_q;
	assign out_valid = oval_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 16'd200;
			dwell_q <= 7'd5;
			quiet_q <= 16'd2000;
			valid_q <= '0;
			fill_q <= '0;
			oval_q <= 1'b0;
			scan_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					pct_pkg::CFG_THRESH: thr_q <= cfg_data;
					pct_pkg::CFG_DWELL: dwell_q <= cfg_data[6:0];
					pct_pkg::CFG_QUIET: quiet_q <= cfg_data;
					default: ;
				endcase
			end
			if (emit_any) begin
				oval_q <= 1'b1;
				out_q <= out_nxt;
			end else if (oval_q && out_ready)
				oval_q <= 1'b0;
			if (cmd.load) begin
				it_q <= in_item;
				scan_q <= '0;
				hit_q <= 1'b0;
				led_q <= 2'd0;
				cc_q <= '0;
			end
			if (cmd.scan) begin
				scan_q <= scan_q + 1'b1;
				if (it_q.req_type == pct_pkg::REQ_MEAS) begin
					if (!hit_q && valid_q[si] && peer_q[si] == it_q.node_id) begin
						hit_q <= 1'b1;
						idx_q <= si;
					end
				end else if (valid_q[si]) begin
					if (new_tick_st == pct_pkg::ST_CLOSE) begin
						led_q <= 2'd3;
						cc_q <= cc_q + 1'b1;
					end else if (new_tick_st == pct_pkg::ST_NEAR && led_q < 2'd2)
						led_q <= 2'd2;
					else if (led_q == 2'd0)
						led_q <= 2'd1;
				end
			end
			if (cmd.tick_upd && valid_q[si]) stat_q[si] <= new_tick_st;
			if (cmd.meas_upd) begin
				if (!hit_q) begin
					idx_q <= fill_q;
					valid_q[fill_q] <= 1'b1;
					peer_q[fill_q] <= it_q.node_id;
					time_q[fill_q] <= it_q.timestamp_ms;
					sum_q[fill_q] <= {16'd0, it_q.distance_cm};
					cnt_q[fill_q] <= 8'd1;
					stat_q[fill_q] <= near ? pct_pkg::ST_NEAR : pct_pkg::ST_NORMAL;
					fill_q <= (fill_q == IW'(PEER_SLOTS-1)) ? '0 : fill_q + 1'b1;
				end else if (st_i == pct_pkg::ST_CLOSE && near) begin
					time_q[idx_q] <= it_q.timestamp_ms;
				end else if (st_i == pct_pkg::ST_NEAR && near) begin
					time_q[idx_q] <= it_q.timestamp_ms;
					sum_q[idx_q] <= sum_q[idx_q] + {16'd0, it_q.distance_cm};
					cnt_q[idx_q] <= cnt_q[idx_q] + 8'd1;
				end else if (st_i != pct_pkg::ST_CLOSE || qp_i) begin
					time_q[idx_q] <= it_q.timestamp_ms;
					sum_q[idx_q] <= {16'd0, it_q.distance_cm};
					cnt_q[idx_q] <= 8'd1;
					stat_q[idx_q] <= near ? pct_pkg::ST_NEAR : pct_pkg::ST_NORMAL;
				end
			end
			if (cmd.div_start) begin
				quo_q <= sum_q[idx_q];
				rem_q <= '0;
				time_q[idx_q] <= it_q.timestamp_ms;
			end
			if (cmd.div_step) begin
				if (rsh >= {25'd0, divisor}) begin
					rem_q <= 32'(rsh - {25'd0, divisor});
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= rsh[31:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end
			if (cmd.div_done) begin
				sum_q[idx_q] <= quo_q;
				stat_q[idx_q] <= pct_pkg::ST_CLOSE;
			end
		end
	end

	// Store flag for a close peer that lapses on a far reading.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lapse_q <= 1'b0;
		else if (cmd.meas_upd) lapse_q <= hit_q && st_i == pct_pkg::ST_CLOSE && !near && qp_i;
	end
endmodule

@@ src/pct_ctrl.sv @@
// ----------------------------------------------------------------------------
// Contact tracker controller
// Sequences lookup, update, division, tick scan and result output.
// ----------------------------------------------------------------------------
module pct_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  pct_pkg::sts_t sts,
	output pct_pkg::cmd_t cmd
);
	typedef enum logic [2:0] {IDLE, SCAN, UPD, DIV, EMIT, TSCAN, TWAIT, SUMW} state_t;
	state_t state_q;
	logic [5:0] cnt_q;

	assign in_ready = state_q == IDLE;

	always_comb begin
		cmd = '0;
		case (state_q)
			IDLE: cmd.load = in_valid;
			SCAN: cmd.scan = !sts.scan_end;
			UPD: begin
				cmd.meas_upd = !sts.need_div || !sts.hit;
				cmd.div_start = sts.need_div && sts.hit;
			end
			DIV: cmd.div_step = cnt_q != 6'd32;
			EMIT: if (!sts.out_full) begin
				cmd.emit_meas = 1'b1;
				cmd.div_done = cnt_q == 6'd32;
			end
			TSCAN: if (!sts.scan_end && !sts.out_full) begin
				cmd.scan = 1'b1;
				cmd.tick_upd = 1'b1;
				cmd.emit_store = sts.store_tick;
			end
			SUMW: cmd.emit_sum = !sts.out_full;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				IDLE: if (in_valid) begin
					cnt_q <= '0;
					state_q <= TWAIT;
				end
				TWAIT: state_q <= sts.is_tick ? TSCAN : SCAN;
				SCAN: if (sts.scan_end) state_q <= UPD;
				UPD: state_q <= (sts.need_div && sts.hit) ? DIV : EMIT;
				DIV: if (cnt_q == 6'd32) state_q <= EMIT;
					else cnt_q <= cnt_q + 1'b1;
				EMIT: if (!sts.out_full) state_q <= IDLE;
				TSCAN: if (sts.scan_end) state_q <= SUMW;
				SUMW: if (!sts.out_full) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

@@ src/proximity_contact_tracker_top.sv @@
// A measurement scans the whole table, then updates the entry; when a
// peer is promoted, the average is divided bit by bit before output.
// A tick scans every slot and can be held by output stalls; one item at a time.
// The serial table scan sets the rate. Reset clears the table valid bits,
// fill pointer and configuration registers to their defaults at once.
// ----------------------------------------------------------------------------
// Proximity contact tracker top
// Tracks ranging peers and reports close contacts and summaries.
// ----------------------------------------------------------------------------
module proximity_contact_tracker_top #(
	parameter int PEER_SLOTS = pct_pkg::PEER_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [15:0] cfg_data,
	pct_stream_if.sink in_ch,
	pct_stream_if.source out_ch
);
	pct_pkg::cmd_t cmd;
	pct_pkg::sts_t sts;
	pct_pkg::out_item_t out_item;
	logic out_valid;

	pct_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.sts(sts), .cmd(cmd)
	);
	pct_datapath #(.PEER_SLOTS(PEER_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_item(pct_pkg::in_item_t'(in_ch.data)), .cmd(cmd),
		.sts(sts), .out_item(out_item), .out_valid(out_valid), .out_ready(out_ch.ready)
	);
	assign out_ch.valid = out_valid;
	assign out_ch.data = out_item;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready) else $error("accept");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ch.ready |=> out_valid && $stable(out_item))
		else $error("output not held");
endmodule
